/* design/hkc_pkg.sv */
// Shared types, constants and key decode functions for the hotkey combo matcher.
package hkc_pkg;

  localparam int MAX_COMBOS = 48;
  localparam int ADDR_W     = (MAX_COMBOS > 1) ? $clog2(MAX_COMBOS) : 1;
  localparam int CNT_W      = $clog2(MAX_COMBOS + 1);

  localparam logic [1:0] CMD_DOWN  = 2'd0;
  localparam logic [1:0] CMD_UP    = 2'd1;
  localparam logic [1:0] CMD_ADD   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [3:0] MOD_NONE  = 4'h0;
  localparam logic [3:0] MOD_ALT   = 4'h1;
  localparam logic [3:0] MOD_CTRL  = 4'h2;
  localparam logic [3:0] SHIFT_MOD = 4'h4;
  localparam logic [3:0] MOD_WIN   = 4'h8;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_DEL   = 8'h2E;
  localparam logic [7:0] KEY_L     = 8'h4C;
  localparam logic [7:0] KEY_LCTRL = 8'hA2;
  localparam logic [7:0] KEY_RCTRL = 8'hA3;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_CAPTURE = 1'b1;

  typedef struct packed {
    logic [7:0] key;
    logic [3:0] mods;
    logic [7:0] id;
  } entry_t;

  typedef struct packed {
    logic       pass_on;
    logic       report_valid;
    logic       report_kind;
    logic [7:0] report_id;
    logic [3:0] report_mods;
    logic [7:0] report_key;
    logic       fake_ctrl;
  } result_t;

  localparam result_t RESULT_PASS = '{pass_on: 1'b1, report_valid: 1'b0,
                                      report_kind: KIND_MATCH, report_id: 8'h00,
                                      report_mods: MOD_NONE, report_key: KEY_NONE,
                                      fake_ctrl: 1'b0};

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP
  } scan_state_t;

  function automatic logic [3:0] mod_of_key(input logic [7:0] k);
    logic [3:0] m;
    m = MOD_NONE;
    if (k == 8'h5B || k == 8'h5C) m = MOD_WIN;
    else if (k == 8'h10 || k == 8'hA0 || k == 8'hA1) m = SHIFT_MOD;
    else if (k == 8'h11 || k == 8'hA2 || k == 8'hA3) m = MOD_CTRL;
    else if (k == 8'h12 || k == 8'hA4 || k == 8'hA5) m = MOD_ALT;
    return m;
  endfunction

  function automatic logic is_single_key(input logic [7:0] k);
    return (k == 8'h13) || (k == 8'h03) || (k >= 8'h70 && k <= 8'h87) ||
           (k >= 8'hA6 && k <= 8'hB7) || (k == 8'h21) || (k == 8'h22);
  endfunction

endpackage

/* design/hkc_table.sv */
// Combo table memory: one write port, one registered read port.
module hkc_table (
  input  logic                 clk,
  input  logic                 we,
  input  logic [hkc_pkg::ADDR_W-1:0] waddr,
  input  hkc_pkg::entry_t      wdata,
  input  logic                 re,
  input  logic [hkc_pkg::ADDR_W-1:0] raddr,
  output hkc_pkg::entry_t      rdata
);
  import hkc_pkg::*;

  entry_t mem [MAX_COMBOS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/hkc_state.sv */
// Held key/modifier tracking, table fill count and per-item decision.
module hkc_state (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [1:0]                 cmd,
  input  logic [7:0]                 key_code,
  input  logic                       injected,
  input  logic [3:0]                 mod_bits,
  input  logic [7:0]                 combo_id,
  input  logic                       match_mode,
  input  logic                       set_suppress,
  output logic [3:0]                 held_mods,
  output logic [7:0]                 held_key,
  output logic [hkc_pkg::CNT_W-1:0]  combo_count,
  output logic                       tbl_we,
  output logic [hkc_pkg::ADDR_W-1:0] tbl_waddr,
  output hkc_pkg::entry_t            tbl_wdata,
  output logic                       imm_valid,
  output hkc_pkg::result_t           imm_result,
  output logic                       scan_start
);
  import hkc_pkg::*;

  logic                 single_flag;
  logic                 suppress_release;
  logic [3:0]           held_mods_next;
  logic [7:0]           held_key_next;
  logic                 single_flag_next;
  logic                 suppress_release_next;
  logic [CNT_W-1:0]     combo_count_next;
  logic [3:0]           key_mod;
  logic                 special;

  assign key_mod = mod_of_key(key_code);
  // Ctrl+Alt+Del or Win+L wipes the held state
  assign special = (key_code == KEY_DEL && held_mods == (MOD_CTRL | MOD_ALT)) ||
                   (key_code == KEY_L && held_mods == MOD_WIN);

  assign tbl_waddr = combo_count[ADDR_W-1:0];
  assign tbl_wdata = '{key: key_code, mods: mod_bits, id: combo_id};

  always_comb begin
    held_mods_next        = held_mods;
    held_key_next         = held_key;
    single_flag_next      = single_flag;
    suppress_release_next = suppress_release;
    combo_count_next      = combo_count;
    tbl_we                = 1'b0;
    imm_valid             = 1'b0;
    scan_start            = 1'b0;
    imm_result            = RESULT_PASS;
    if (accept) begin
      case (cmd)
        CMD_ADD: begin
          imm_valid          = 1'b1;
          imm_result.pass_on = 1'b0;
          if (combo_count < CNT_W'(MAX_COMBOS)) begin
            tbl_we           = 1'b1;
            combo_count_next = combo_count + CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          imm_valid          = 1'b1;
          imm_result.pass_on = 1'b0;
          combo_count_next   = '0;
        end
        default: begin
          if (injected && (key_code == KEY_LCTRL || key_code == KEY_RCTRL)) begin
            imm_valid = 1'b1;
          end else if (special) begin
            imm_valid        = 1'b1;
            held_mods_next   = MOD_NONE;
            held_key_next    = KEY_NONE;
            single_flag_next = 1'b0;
          end else if (cmd == CMD_DOWN) begin
            if (match_mode) begin
              suppress_release_next = 1'b0;
              if (key_mod != MOD_NONE) held_mods_next = held_mods | key_mod;
              else held_key_next = key_code;
              if (key_code != KEY_NONE && key_code == held_key_next) begin
                scan_start = 1'b1;
              end else begin
                imm_valid = 1'b1;
              end
            end else begin
              imm_valid = 1'b1;
              if (key_mod != MOD_NONE) begin
                held_mods_next = held_mods | key_mod;
              end else begin
                held_key_next = key_code;
                if (is_single_key(key_code)) single_flag_next = 1'b1;
              end
              if ((held_mods_next != MOD_NONE || single_flag_next) &&
                  held_key_next != KEY_NONE) begin
                imm_result.pass_on      = 1'b0;
                imm_result.report_valid = 1'b1;
                imm_result.report_kind  = KIND_CAPTURE;
                imm_result.report_mods  = held_mods_next;
                imm_result.report_key   = held_key_next;
              end
            end
          end else begin
            imm_valid = 1'b1;
            if (key_mod != MOD_NONE) begin
              held_mods_next = held_mods & ~key_mod;
            end else if (key_code != KEY_NONE && held_key == key_code) begin
              held_key_next    = KEY_NONE;
              single_flag_next = 1'b0;
            end
            if (suppress_release) imm_result.pass_on = (key_mod != MOD_NONE);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mods        <= MOD_NONE;
      held_key         <= KEY_NONE;
      single_flag      <= 1'b0;
      suppress_release <= 1'b0;
      combo_count      <= '0;
    end else begin
      held_mods        <= held_mods_next;
      held_key         <= held_key_next;
      single_flag      <= single_flag_next;
      suppress_release <= set_suppress ? 1'b1 : suppress_release_next;
      combo_count      <= combo_count_next;
    end
  end

endmodule

/* design/hkc_scan.sv */
// Table scan sequencer: each entry is read in S_READ and compared in S_CMP.
module hkc_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [hkc_pkg::CNT_W-1:0]  combo_count,
  input  logic [3:0]                 held_mods,
  input  logic [7:0]                 held_key,
  input  hkc_pkg::entry_t            rd_data,
  output logic                       rd_en,
  output logic [hkc_pkg::ADDR_W-1:0] rd_addr,
  output logic                       busy,
  output logic                       done,
  output logic                       set_suppress,
  output hkc_pkg::result_t           result
);
  import hkc_pkg::*;

  scan_state_t      state;
  scan_state_t      state_next;
  logic [CNT_W-1:0] idx;
  logic             at_end;
  logic             hit;

  assign at_end  = (idx == combo_count);
  assign hit     = (rd_data.key == held_key) && (rd_data.mods == held_mods);
  assign rd_addr = idx[ADDR_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_READ;
      S_READ:  state_next = at_end ? S_IDLE : S_CMP;
      S_CMP:   state_next = hit ? S_IDLE : S_READ;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en        = 1'b0;
    done         = 1'b0;
    set_suppress = 1'b0;
    busy         = (state != S_IDLE);
    result       = RESULT_PASS;
    case (state)
      S_READ: begin
        rd_en = !at_end;
        done  = at_end;
      end
      S_CMP: begin
        if (hit) begin
          done                = 1'b1;
          set_suppress        = 1'b1;
          result.pass_on      = 1'b0;
          result.report_valid = 1'b1;
          result.report_kind  = KIND_MATCH;
          result.report_id    = rd_data.id;
          result.fake_ctrl    = (held_mods == MOD_ALT) || (held_mods == MOD_WIN);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) idx <= '0;
      else if (state == S_CMP && !hit) idx <= idx + CNT_W'(1);
    end
  end

endmodule

/* design/hotkey_combo_matcher.sv */
// Top level of the hotkey combo matcher: handshakes, mode register, output register.
// Timing: add, clear, key up, capture and pass-through items show their result in the cycle
//   after acceptance; a match-mode key down of a non-modifier key scans the table, reading
//   each entry in S_READ and comparing it in S_CMP (N stored combos, at most 48).
// Throughput: one item at a time; the next waits for an idle scan and an unstalled output.
// Reset (rst, synchronous): clears held keys, flags, combo count, mode and output valid.
module hotkey_combo_matcher (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] key_code,
  input  logic       injected,
  input  logic [3:0] mod_bits,
  input  logic [7:0] combo_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       pass_on,
  output logic       report_valid,
  output logic       report_kind,
  output logic [7:0] report_id,
  output logic [3:0] report_mods,
  output logic [7:0] report_key,
  output logic       fake_ctrl,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import hkc_pkg::*;

  logic                 match_mode;
  logic                 accept;
  logic [3:0]           held_mods;
  logic [7:0]           held_key;
  logic [CNT_W-1:0]     combo_count;
  logic                 tbl_we;
  logic [ADDR_W-1:0]    tbl_waddr;
  entry_t               tbl_wdata;
  logic                 tbl_re;
  logic [ADDR_W-1:0]    tbl_raddr;
  entry_t               tbl_rdata;
  logic                 imm_valid;
  result_t              imm_result;
  logic                 scan_start;
  logic                 scan_busy;
  logic                 scan_done;
  logic                 set_suppress;
  result_t              scan_result;
  result_t              out_reg;

  // output register is free whenever no unaccepted result sits in it
  assign in_stall = scan_busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  hkc_state u_state (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .key_code    (key_code),
    .injected    (injected),
    .mod_bits    (mod_bits),
    .combo_id    (combo_id),
    .match_mode  (match_mode),
    .set_suppress(set_suppress),
    .held_mods   (held_mods),
    .held_key    (held_key),
    .combo_count (combo_count),
    .tbl_we      (tbl_we),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata),
    .imm_valid   (imm_valid),
    .imm_result  (imm_result),
    .scan_start  (scan_start)
  );

  hkc_table u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re   (tbl_re),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  hkc_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .combo_count (combo_count),
    .held_mods   (held_mods),
    .held_key    (held_key),
    .rd_data     (tbl_rdata),
    .rd_en       (tbl_re),
    .rd_addr     (tbl_raddr),
    .busy        (scan_busy),
    .done        (scan_done),
    .set_suppress(set_suppress),
    .result      (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) match_mode <= cfg_wdata;
      if (imm_valid || scan_done) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm_valid) out_reg <= imm_result;
    else if (scan_done) out_reg <= scan_result;
  end

  assign pass_on      = out_reg.pass_on;
  assign report_valid = out_reg.report_valid;
  assign report_kind  = out_reg.report_kind;
  assign report_id    = out_reg.report_id;
  assign report_mods  = out_reg.report_mods;
  assign report_key   = out_reg.report_key;
  assign fake_ctrl    = out_reg.fake_ctrl;

endmodule

/* design/hkc_checker.sv */
// Port-level checks for the hotkey combo matcher, bound to the top level.
module hkc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       pass_on,
  input logic       report_valid,
  input logic       report_kind,
  input logic [7:0] report_id,
  input logic [3:0] report_mods,
  input logic [7:0] report_key,
  input logic       fake_ctrl
);
  import hkc_pkg::*;

  // a reported match or chord always swallows the event
  a_report_swallows: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |-> !pass_on)
    else $error("reported item passed on");

  a_match_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid && report_kind == KIND_MATCH |->
      report_mods == MOD_NONE && report_key == KEY_NONE)
    else $error("match carries chord fields");

  a_capture_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid && report_kind == KIND_CAPTURE |->
      report_id == 8'h00 && !fake_ctrl && report_key != KEY_NONE)
    else $error("capture fields inconsistent");

  a_no_report_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid |->
      !fake_ctrl && report_id == 8'h00 && report_mods == MOD_NONE)
    else $error("fields set without report");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({pass_on, report_valid, report_kind, report_id, report_mods,
               report_key, fake_ctrl}))
    else $error("stalled result changed");

endmodule

bind hotkey_combo_matcher hkc_checker u_hkc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pass_on     (pass_on),
  .report_valid(report_valid),
  .report_kind (report_kind),
  .report_id   (report_id),
  .report_mods (report_mods),
  .report_key  (report_key),
  .fake_ctrl   (fake_ctrl)
);
